>>> hdl/heater_pid_duty_controller_defines.svh
// ----------------------------------------------------------------------------
// heater_pid_duty_controller_defines
// Assertion macros shared by the heater PID duty controller RTL. Each macro
// expects signals named clk and rst_n in the module that uses it.
// ----------------------------------------------------------------------------
`ifndef HEATER_PID_DUTY_CONTROLLER_DEFINES_SVH
`define HEATER_PID_DUTY_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define HPID_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("heater pid: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define HPID_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("heater pid: next-cycle check failed");

`endif

>>> hdl/hpid_pkg.sv
// ----------------------------------------------------------------------------
// hpid_pkg
// Widths, register indexes, reset values and the configuration bundle of
// the heater PID duty controller.
// ----------------------------------------------------------------------------
package hpid_pkg;

  // Field widths
  localparam int TEMP_W    = 16;
  localparam int TICK_W    = 16;
  localparam int GAIN_W    = 24;
  localparam int DUTY_W    = 8;
  localparam int MODE_W    = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_PID_ENABLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MANUAL_DUTY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_TEMP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = 3'd6;

  // Reset values of the registers that are not zero
  localparam logic              PID_ENABLE_RST  = 1'b1;
  localparam logic [TICK_W-1:0] TICK_PERIOD_RST = 16'd100;

  // Result mode codes
  localparam logic [MODE_W-1:0] MODE_MANUAL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_IDLE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PID    = 2'd2;

  localparam logic [DUTY_W-1:0] DUTY_MAX = 8'd255;

  // Datapath widths
  localparam int DIFF_W  = TEMP_W + 1;          // target - measured
  localparam int ERR_W   = 34;                  // tick_period * diff
  localparam int DLT_W   = ERR_W + 1;           // error - previous error
  localparam int INTEG_W = 48;
  localparam int MUL_A_W = GAIN_W + 1;          // holds gain or zero-extended tick
  localparam int MUL_B_W = 18;                  // one slice of the multiplicand
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int LO_W    = MUL_B_W - 1;         // unsigned low slice
  localparam int ACC_W   = 60;                  // gain * delta, exact
  localparam int FRAC_W  = 16;
  localparam int TERM_W  = ACC_W - FRAC_W;
  localparam int IG_W    = INTEG_W + 2;
  localparam int SUM_W   = IG_W + 1;

  // Configuration register bundle
  typedef struct packed {
    logic                     pid_enable;
    logic [DUTY_W-1:0]        manual_duty;
    logic [TICK_W-1:0]        tick_period;
    logic signed [TEMP_W-1:0] target_temp;
    logic signed [GAIN_W-1:0] prop_gain;
    logic signed [GAIN_W-1:0] integ_gain;
    logic signed [GAIN_W-1:0] deriv_gain;
  } cfg_t;

endpackage

>>> hdl/hpid_cfg.sv
// ----------------------------------------------------------------------------
// hpid_cfg
// Configuration register file: one write per cycle, unknown indexes dropped.
// ----------------------------------------------------------------------------
module hpid_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [hpid_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hpid_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output hpid_pkg::cfg_t                   cfg
);
  import hpid_pkg::*;

  cfg_t cfg_r;

  // Write the addressed register, drop writes beyond the list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pid_enable  <= PID_ENABLE_RST;
      cfg_r.manual_duty <= '0;
      cfg_r.tick_period <= TICK_PERIOD_RST;
      cfg_r.target_temp <= '0;
      cfg_r.prop_gain   <= '0;
      cfg_r.integ_gain  <= '0;
      cfg_r.deriv_gain  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PID_ENABLE:  cfg_r.pid_enable  <= cfg_wdata[0];
        REG_MANUAL_DUTY: cfg_r.manual_duty <= cfg_wdata[DUTY_W-1:0];
        REG_TICK_PERIOD: cfg_r.tick_period <= cfg_wdata[TICK_W-1:0];
        REG_TARGET_TEMP: cfg_r.target_temp <= signed'(cfg_wdata[TEMP_W-1:0]);
        REG_PROP_GAIN:   cfg_r.prop_gain   <= signed'(cfg_wdata[GAIN_W-1:0]);
        REG_INTEG_GAIN:  cfg_r.integ_gain  <= signed'(cfg_wdata[GAIN_W-1:0]);
        REG_DERIV_GAIN:  cfg_r.deriv_gain  <= signed'(cfg_wdata[GAIN_W-1:0]);
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> hdl/hpid_mul.sv
// ----------------------------------------------------------------------------
// hpid_mul
// Shared signed 25 x 18 multiplier with a registered product.
// ----------------------------------------------------------------------------
module hpid_mul (
  input  logic                                clk,
  input  logic signed [hpid_pkg::MUL_A_W-1:0] mul_a,
  input  logic signed [hpid_pkg::MUL_B_W-1:0] mul_b,
  output logic signed [hpid_pkg::MUL_P_W-1:0] prod_r
);
  import hpid_pkg::*;

  // Register the product every cycle
  always_ff @(posedge clk) begin
    prod_r <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
  end

endmodule

>>> hdl/heater_pid_duty_controller.sv
// ----------------------------------------------------------------------------
// heater_pid_duty_controller
// Turns one temperature sample per control tick into an 8-bit heater duty
// using a PID law with a clamped integral, or a manual or idle-mode duty.
// ----------------------------------------------------------------------------
// One word in, one word out. A manual-mode or idle-mode word is accepted and
// its result goes to the result registers, then to the output register once
// that is empty or being taken. A PID word runs DLT, then MLO, MHI, ACC and
// FIN per gain term, then SUM and PUT: one shared signed 25 x 18 multiplier
// is used seven times (once for the scaled error, twice per gain term, each
// gain product split into a low and a high slice of the error, or of the
// error change for the derivative), with an accumulate and a floor step per
// term and a clamp on the integral. in_ready is high only while the
// sequencer is idle, so a word is taken only after the last has left it;
// a result waiting in the output register does not block the next one.
`include "heater_pid_duty_controller_defines.svh"

module heater_pid_duty_controller (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [hpid_pkg::TEMP_W-1:0] in_measured_temp,
  input  logic                               in_session_running,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [hpid_pkg::DUTY_W-1:0]        out_duty,
  output logic [hpid_pkg::MODE_W-1:0]        out_mode_taken,
  output logic                               out_clamped,
  // configuration port
  input  logic                               cfg_we,
  input  logic [hpid_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hpid_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import hpid_pkg::*;

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DLT  = 3'd1;
  localparam logic [2:0] ST_MLO  = 3'd2;
  localparam logic [2:0] ST_MHI  = 3'd3;
  localparam logic [2:0] ST_ACC  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;
  localparam logic [2:0] ST_SUM  = 3'd6;
  localparam logic [2:0] ST_PUT  = 3'd7;

  // Gain term being worked on
  localparam logic [1:0] TERM_P = 2'd0;
  localparam logic [1:0] TERM_I = 2'd1;
  localparam logic [1:0] TERM_D = 2'd2;

  cfg_t cfg;

  logic [2:0]                 state_r,     state_nxt;
  logic [1:0]                 term_sel_r,  term_sel_nxt;
  logic signed [ERR_W-1:0]    prev_r,      prev_nxt;
  logic [INTEG_W-1:0]         integ_r,     integ_nxt;
  logic signed [DLT_W-1:0]    dlt_r,       dlt_nxt;
  logic signed [ACC_W-1:0]    acc_r,       acc_nxt;
  logic signed [IG_W-1:0]     term_r,      term_nxt;
  logic signed [SUM_W-1:0]    sum_r,       sum_nxt;
  logic [DUTY_W-1:0]          res_duty_r,  res_duty_nxt;
  logic [MODE_W-1:0]          res_mode_r,  res_mode_nxt;
  logic                       res_clamp_r, res_clamp_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [DUTY_W-1:0]          out_duty_r,  out_duty_nxt;
  logic [MODE_W-1:0]          out_mode_r,  out_mode_nxt;
  logic                       out_clamp_r, out_clamp_nxt;

  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [MUL_P_W-1:0]  prod_r;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [ERR_W-1:0]    err;
  logic signed [GAIN_W-1:0]   gain;
  logic signed [DLT_W-1:0]    xop;
  logic signed [TERM_W-1:0]   tq;
  logic signed [IG_W-1:0]     ig_sum;
  logic [INTEG_W-1:0]         ig_clamp;
  logic signed [SUM_W-1:0]    total;
  logic                       accept;
  logic                       put_go;

  hpid_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  hpid_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign put_go   = (state_r == ST_PUT) && (!out_valid_r || out_ready);

  // Select the gain and the multiplicand of the current term
  always_comb begin
    case (term_sel_r)
      TERM_P:  gain = cfg.prop_gain;
      TERM_I:  gain = cfg.integ_gain;
      default: gain = cfg.deriv_gain;
    endcase
    xop = (term_sel_r == TERM_D) ? dlt_r : DLT_W'(prev_r);
  end

  // Drive the shared multiplier: scaled error while idle, gain slices later
  always_comb begin
    diff = DIFF_W'(cfg.target_temp) - DIFF_W'(in_measured_temp);
    case (state_r)
      ST_IDLE: begin
        mul_a = signed'(MUL_A_W'(cfg.tick_period));
        mul_b = MUL_B_W'(diff);
      end
      ST_MLO: begin
        mul_a = MUL_A_W'(gain);
        mul_b = signed'({1'b0, xop[LO_W-1:0]});
      end
      default: begin
        mul_a = MUL_A_W'(gain);
        mul_b = signed'(xop[DLT_W-1:LO_W]);
      end
    endcase
  end

  // Floor the product, clamp the integral, sum the terms
  always_comb begin
    err    = signed'(prod_r[ERR_W-1:0]);
    tq     = TERM_W'(acc_r >>> FRAC_W);
    ig_sum = IG_W'(signed'({1'b0, integ_r})) + IG_W'(tq);
    if (ig_sum[IG_W-1]) begin
      ig_clamp = '0;
    end else if (|ig_sum[IG_W-2:INTEG_W]) begin
      ig_clamp = '1;
    end else begin
      ig_clamp = ig_sum[INTEG_W-1:0];
    end
    total = sum_r + SUM_W'(term_r);
  end

  // Sequencer and datapath next values
  always_comb begin
    state_nxt     = state_r;
    term_sel_nxt  = term_sel_r;
    prev_nxt      = prev_r;
    integ_nxt     = integ_r;
    dlt_nxt       = dlt_r;
    acc_nxt       = acc_r;
    term_nxt      = term_r;
    sum_nxt       = sum_r;
    res_duty_nxt  = res_duty_r;
    res_mode_nxt  = res_mode_r;
    res_clamp_nxt = res_clamp_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (!cfg.pid_enable) begin
            res_duty_nxt  = cfg.manual_duty;
            res_mode_nxt  = MODE_MANUAL;
            res_clamp_nxt = 1'b0;
            state_nxt     = ST_PUT;
          end else if (!in_session_running) begin
            res_duty_nxt  = '0;
            res_mode_nxt  = MODE_IDLE;
            res_clamp_nxt = 1'b0;
            state_nxt     = ST_PUT;
          end else begin
            state_nxt = ST_DLT;
          end
        end
      end
      ST_DLT: begin
        // store the new error and the error change
        prev_nxt     = err;
        dlt_nxt      = DLT_W'(err) - DLT_W'(prev_r);
        term_nxt     = '0;
        sum_nxt      = '0;
        term_sel_nxt = TERM_P;
        state_nxt    = ST_MLO;
      end
      ST_MLO: begin
        sum_nxt   = total;
        state_nxt = ST_MHI;
      end
      ST_MHI: begin
        acc_nxt   = ACC_W'(prod_r);
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        acc_nxt   = acc_r + (ACC_W'(prod_r) <<< LO_W);
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (term_sel_r == TERM_I) begin
          integ_nxt = ig_clamp;
          term_nxt  = IG_W'(signed'({1'b0, ig_clamp}));
        end else begin
          term_nxt = IG_W'(tq);
        end
        if (term_sel_r == TERM_D) begin
          state_nxt = ST_SUM;
        end else begin
          term_sel_nxt = term_sel_r + 2'd1;
          state_nxt    = ST_MLO;
        end
      end
      ST_SUM: begin
        // clamp the PID sum to the duty range
        res_mode_nxt = MODE_PID;
        if (total[SUM_W-1]) begin
          res_duty_nxt  = '0;
          res_clamp_nxt = 1'b1;
        end else if (|total[SUM_W-2:DUTY_W]) begin
          res_duty_nxt  = DUTY_MAX;
          res_clamp_nxt = 1'b1;
        end else begin
          res_duty_nxt  = total[DUTY_W-1:0];
          res_clamp_nxt = 1'b0;
        end
        state_nxt = ST_PUT;
      end
      ST_PUT: begin
        if (put_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output register: load on hand-over, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_duty_nxt  = out_duty_r;
    out_mode_nxt  = out_mode_r;
    out_clamp_nxt = out_clamp_r;
    if (put_go) begin
      out_valid_nxt = 1'b1;
      out_duty_nxt  = res_duty_r;
      out_mode_nxt  = res_mode_r;
      out_clamp_nxt = res_clamp_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control and stored terms
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      term_sel_r  <= TERM_P;
      prev_r      <= '0;
      integ_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      term_sel_r  <= term_sel_nxt;
      prev_r      <= prev_nxt;
      integ_r     <= integ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result payload
  always_ff @(posedge clk) begin
    dlt_r       <= dlt_nxt;
    acc_r       <= acc_nxt;
    term_r      <= term_nxt;
    sum_r       <= sum_nxt;
    res_duty_r  <= res_duty_nxt;
    res_mode_r  <= res_mode_nxt;
    res_clamp_r <= res_clamp_nxt;
    out_duty_r  <= out_duty_nxt;
    out_mode_r  <= out_mode_nxt;
    out_clamp_r <= out_clamp_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_duty       = out_duty_r;
  assign out_mode_taken = out_mode_r;
  assign out_clamped    = out_clamp_r;

  // Checks
  `HPID_ASSERT_NXT(a_accept_leaves_idle, accept, state_r == ST_DLT || state_r == ST_PUT)
  `HPID_ASSERT_IMP(a_clamp_only_pid, out_valid_r && out_mode_r != MODE_PID, !out_clamp_r)
  `HPID_ASSERT_IMP(a_clamp_at_rail, out_valid_r && out_clamp_r, out_duty_r == '0 || out_duty_r == DUTY_MAX)
  `HPID_ASSERT_IMP(a_idle_zero_duty, out_valid_r && out_mode_r == MODE_IDLE, out_duty_r == '0)
  `HPID_ASSERT_IMP(a_prev_err_update, prev_r != $past(prev_r), $past(state_r) == ST_DLT)

endmodule

>>> tb/tb_heater_pid_duty_controller.sv
// ----------------------------------------------------------------------------
// tb_heater_pid_duty_controller
// Self-checking bench for the heater PID duty controller. A local model of the
// PID law, with its own copy of the registers, the integral and the last
// error, predicts every result word. Directed ticks cover the manual, idle and
// PID modes and the clamp corners. Random phases follow with bursty handshakes
// and one long output hold-off. A final run drives the integral into
// saturation with no idling on either side.
// ----------------------------------------------------------------------------
module tb_heater_pid_duty_controller;
  import hpid_pkg::*;

  localparam int     HALF_PERIOD  = 6;
  localparam int     CYCLE_LIMIT  = 400000;
  localparam int     OUTAGE_LEN   = 300;
  localparam int     DRAIN_CYCLES = 16;
  localparam int     FRAC_BITS    = 16;
  localparam longint INTEG_TOP    = 64'h0000_FFFF_FFFF_FFFF;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic [MODE_W-1:0] mode;
    logic              clamped;
  } duty_word_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [TEMP_W-1:0]   in_measured_temp;
  logic                       in_session_running;
  logic                       out_valid;
  logic                       out_ready;
  logic [DUTY_W-1:0]          out_duty;
  logic [MODE_W-1:0]          out_mode_taken;
  logic                       out_clamped;
  logic                       cfg_we;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_wdata;

  // Local copy of the registers and of the controller state
  cfg_t       reg_copy;
  longint     integ_acc;
  longint     last_error;
  duty_word_t pending_duty_q[$];

  int  errors;
  int  cycles;
  bit  bursty;
  bit  outage_req;
  int  outage_left;
  int  stall_left;

  heater_pid_duty_controller u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_measured_temp  (in_measured_temp),
    .in_session_running(in_session_running),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_duty          (out_duty),
    .out_mode_taken    (out_mode_taken),
    .out_clamped       (out_clamped),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #HALF_PERIOD;
    clk = 1'b1;
    #HALF_PERIOD;
  end

  // Compute the result word of one tick and advance the PID state
  function automatic duty_word_t next_duty_word(input logic signed [TEMP_W-1:0] meas,
                                                input logic run);
    duty_word_t w;
    longint     err;
    longint     p_term;
    longint     i_sum;
    longint     d_term;
    longint     total;
    w.clamped = 1'b0;
    if (!reg_copy.pid_enable) begin
      w.duty = reg_copy.manual_duty;
      w.mode = MODE_MANUAL;
      return w;
    end
    if (!run) begin
      w.duty = '0;
      w.mode = MODE_IDLE;
      return w;
    end
    err = longint'(reg_copy.tick_period) *
          (longint'($signed(reg_copy.target_temp)) - longint'(meas));
    p_term = (longint'($signed(reg_copy.prop_gain)) * err) >>> FRAC_BITS;
    i_sum  = integ_acc + ((longint'($signed(reg_copy.integ_gain)) * err) >>> FRAC_BITS);
    if (i_sum < 0) i_sum = 0;
    if (i_sum > INTEG_TOP) i_sum = INTEG_TOP;
    integ_acc = i_sum;
    d_term = (longint'($signed(reg_copy.deriv_gain)) * (err - last_error)) >>> FRAC_BITS;
    last_error = err;
    total = p_term + i_sum + d_term;
    w.mode = MODE_PID;
    if (total < 0) begin
      w.duty    = '0;
      w.clamped = 1'b1;
    end else if (total > longint'(DUTY_MAX)) begin
      w.duty    = DUTY_MAX;
      w.clamped = 1'b1;
    end else begin
      w.duty = total[DUTY_W-1:0];
    end
    return w;
  endfunction

  // Offer one tick word, hold it until accepted, then queue its result
  task automatic send_tick(input logic signed [TEMP_W-1:0] meas, input logic run);
    int gap;
    gap = (bursty && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid           = 1'b1;
    in_measured_temp   = meas;
    in_session_running = run;
    do @(posedge clk); while (!in_ready);
    pending_duty_q.push_back(next_duty_word(meas, run));
  endtask

  // Drop valid and wait for every queued result
  task automatic drain;
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_duty_q.size() != 0) @(posedge clk);
  endtask

  // Write one register and mirror it into the local copy
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we    = 1'b0;
    case (idx)
      REG_PID_ENABLE:  reg_copy.pid_enable  = data[0];
      REG_MANUAL_DUTY: reg_copy.manual_duty = data[DUTY_W-1:0];
      REG_TICK_PERIOD: reg_copy.tick_period = data[TICK_W-1:0];
      REG_TARGET_TEMP: reg_copy.target_temp = data[TEMP_W-1:0];
      REG_PROP_GAIN:   reg_copy.prop_gain   = data[GAIN_W-1:0];
      REG_INTEG_GAIN:  reg_copy.integ_gain  = data[GAIN_W-1:0];
      REG_DERIV_GAIN:  reg_copy.deriv_gain  = data[GAIN_W-1:0];
      default: ;
    endcase
  endtask

  // Reset values: PID on, zero gains, so running ticks give zero duty
  task automatic check_reset_state;
    send_tick(16'sh7FFF, 1'b0);
    send_tick(-16'sh8000, 1'b1);
    send_tick(16'sh7FFF, 1'b1);
    drain();
  endtask

  // Manual duty at both extremes; an unused register index changes nothing
  task automatic check_manual_mode;
    write_reg(REG_PID_ENABLE, '0);
    write_reg(REG_MANUAL_DUTY, 24'd255);
    send_tick(16'sh1234, 1'b1);
    send_tick(-16'sh1234, 1'b0);
    drain();
    write_reg(REG_MANUAL_DUTY, '0);
    send_tick(16'sh0000, 1'b1);
    drain();
    write_reg(REG_UNUSED, '1);
    send_tick(16'sh0055, 1'b0);
    drain();
    write_reg(REG_PID_ENABLE, 24'd1);
  endtask

  // Clamp corners, integral floor, zero tick period and extreme gains
  task automatic check_pid_corners;
    write_reg(REG_TICK_PERIOD, 24'd1);
    write_reg(REG_TARGET_TEMP, 24'd100);
    write_reg(REG_PROP_GAIN, 24'd65536);
    send_tick(16'sd100, 1'b1);
    send_tick(16'sd0, 1'b1);
    send_tick(-16'sh8000, 1'b1);
    send_tick(16'sh7FFF, 1'b1);
    drain();
    // negative error pulls the integral under zero
    write_reg(REG_PROP_GAIN, '0);
    write_reg(REG_INTEG_GAIN, 24'd65536);
    write_reg(REG_TARGET_TEMP, '0);
    send_tick(16'sd100, 1'b1);
    send_tick(-16'sd10, 1'b1);
    send_tick(-16'sd10, 1'b0);
    send_tick(-16'sd20, 1'b1);
    drain();
    // derivative at both gain extremes
    write_reg(REG_INTEG_GAIN, '0);
    write_reg(REG_DERIV_GAIN, 24'h800000);
    send_tick(-16'sd3, 1'b1);
    send_tick(16'sd3, 1'b1);
    drain();
    write_reg(REG_DERIV_GAIN, 24'h7FFFFF);
    write_reg(REG_TICK_PERIOD, 24'd65535);
    write_reg(REG_TARGET_TEMP, 24'h007FFF);
    send_tick(16'sh7FFF, 1'b1);
    send_tick(16'sh7FFE, 1'b1);
    drain();
    // zero tick period forces a zero error
    write_reg(REG_TICK_PERIOD, '0);
    write_reg(REG_PROP_GAIN, 24'h7FFFFF);
    send_tick(-16'sh8000, 1'b1);
    send_tick(16'sh0000, 1'b1);
    drain();
  endtask

  // Random register settings, ticks mostly near the setpoint
  task automatic check_random_ticks;
    logic signed [TEMP_W-1:0] meas;
    for (int phase = 0; phase < 8; phase++) begin
      write_reg(REG_PID_ENABLE, ($urandom_range(0, 5) != 0) ? 24'd1 : 24'd0);
      write_reg(REG_MANUAL_DUTY, 24'($urandom_range(0, 255)));
      write_reg(REG_TICK_PERIOD, ($urandom_range(0, 3) == 0) ? 24'($urandom_range(0, 65535))
                                                              : 24'($urandom_range(1, 20)));
      write_reg(REG_TARGET_TEMP, 24'($urandom_range(0, 65535)));
      write_reg(REG_PROP_GAIN, ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                                           : 24'($urandom_range(0, 131072) - 65536));
      write_reg(REG_INTEG_GAIN, ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                                            : 24'($urandom_range(0, 8192) - 4096));
      write_reg(REG_DERIV_GAIN, ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                                            : 24'($urandom_range(0, 131072) - 65536));
      // hold the result side off once so the block backs up into its input
      if (phase == 2) outage_req = 1'b1;
      for (int n = 0; n < 28; n++) begin
        if ($urandom_range(0, 3) == 0) meas = 16'($urandom);
        else meas = 16'(int'(reg_copy.target_temp) + $urandom_range(0, 200) - 100);
        send_tick(meas, $urandom_range(0, 4) != 0);
      end
      drain();
    end
  endtask

  // Push the integral to its upper bound and keep it there for a while
  task automatic check_integral_saturation;
    int extra;
    int n;
    write_reg(REG_PID_ENABLE, 24'd1);
    write_reg(REG_TICK_PERIOD, 24'd65535);
    write_reg(REG_TARGET_TEMP, 24'h007FFF);
    write_reg(REG_PROP_GAIN, 24'h800000);
    write_reg(REG_INTEG_GAIN, 24'h7FFFFF);
    write_reg(REG_DERIV_GAIN, 24'($urandom_range(0, 131072) - 65536));
    extra = 0;
    n = 0;
    while (extra < 8 && n < 700) begin
      send_tick(16'(-32768 + $urandom_range(0, 40)), $urandom_range(0, 19) != 0);
      if (integ_acc == INTEG_TOP) extra++;
      n++;
    end
    drain();
  endtask

  // Drive out_ready: long outage on request, short random stalls otherwise
  always @(negedge clk) begin
    if (outage_req) begin
      outage_req  = 1'b0;
      outage_left = OUTAGE_LEN;
    end
    if (outage_left > 0) begin
      out_ready = 1'b0;
      outage_left--;
    end else if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else if (bursty && $urandom_range(0, 5) == 0) begin
      out_ready  = 1'b0;
      stall_left = $urandom_range(1, 8) - 1;
    end else begin
      out_ready = 1'b1;
    end
  end

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk) begin
    duty_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_duty_q.size() == 0) begin
        $error("result word with no tick pending");
        errors++;
      end else begin
        want = pending_duty_q.pop_front();
        if (out_duty !== want.duty) begin
          $error("duty expected %0d got %0d", want.duty, out_duty);
          errors++;
        end
        if (out_mode_taken !== want.mode) begin
          $error("mode_taken expected %0d got %0d", want.mode, out_mode_taken);
          errors++;
        end
        if (out_clamped !== want.clamped) begin
          $error("clamped expected %0d got %0d", want.clamped, out_clamped);
          errors++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_heater_pid_duty_controller NOT OK");
      $finish;
    end
  end

  initial begin
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_measured_temp   = '0;
    in_session_running = 1'b0;
    out_ready          = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_wdata          = '0;
    errors             = 0;
    cycles             = 0;
    bursty             = 1'b1;
    outage_req         = 1'b0;
    outage_left        = 0;
    stall_left         = 0;
    integ_acc          = 0;
    last_error         = 0;
    reg_copy             = '0;
    reg_copy.pid_enable  = PID_ENABLE_RST;
    reg_copy.tick_period = TICK_PERIOD_RST;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    check_reset_state();
    check_manual_mode();
    check_pid_corners();
    check_random_ticks();
    bursty = 1'b0;
    check_integral_saturation();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_duty_q.size() == 0) begin
      $display("tb_heater_pid_duty_controller OK");
    end else begin
      $display("tb_heater_pid_duty_controller NOT OK");
    end
    $finish;
  end

endmodule
